FILE: design/mcspg_pkg.sv
// ----------------------------------------------------------------------------
// mcspg_pkg: shared types and constants for the servo pulse generator
// Field widths, the valid pin table, register indexes and the angle to
// high time mapping.
// ----------------------------------------------------------------------------
package mcspg_pkg;

  localparam int NumChannels = 9;   // 1..16
  localparam int MaskWidth   = 9;
  localparam int TableLen    = 9;

  localparam int PinW     = 5;
  localparam int AngleW   = 10;
  localparam int FrameW   = 14;
  localparam int StopW    = 16;
  localparam int HighW    = 12;
  localparam int MsW      = 32;
  localparam int PrescW   = 10;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [PinW-1:0] PinTable [TableLen] = '{
    5'd0, 5'd2, 5'd4, 5'd5, 5'd10, 5'd16, 5'd14, 5'd12, 5'd13
  };
  localparam logic [PinW-1:0] HoldPin = 5'd10;

  localparam logic [PrescW-1:0] UsPerMs    = 10'd1000;
  localparam logic [FrameW-1:0] FrameReset = 14'd12000;
  localparam logic [StopW-1:0]  StopReset  = 16'd1000;

  localparam logic signed [AngleW-1:0] AngleMax = 10'sd180;
  localparam logic [HighW-1:0]         HighBase = 12'd500;
  // round(2^16 * 2000 / 180), exact floor for angles up to 180
  localparam logic [19:0]              RecipScale = 20'd728178;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_US      = 2'd0,
    REG_STOP_AFTER_MS = 2'd1
  } cfg_reg_e;

  // clamp to 0..180 and map to 500 + angle*2000/180, truncated
  function automatic logic [HighW-1:0] high_time(input logic signed [AngleW-1:0] angle);
    logic [7:0]  a;
    logic [27:0] prod;
    if (angle < 0) begin
      a = 8'd0;
    end else if (angle > AngleMax) begin
      a = AngleMax[7:0];
    end else begin
      a = angle[7:0];
    end
    prod = 28'(a) * 28'(RecipScale);
    return HighBase + prod[27:16];
  endfunction

endpackage

FILE: design/multi_channel_servo_pulse_generator.sv
// ----------------------------------------------------------------------------
// multi_channel_servo_pulse_generator: nine-channel hobby-servo pulse source
// Items are either a one microsecond tick or a start of one channel; each
// item yields one result with all pin levels and the running mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries command, pin and angle.
//   command = tick advances every running channel by one microsecond;
//   command = start looks the pin up in the valid pin table and (re)starts
//   that channel with a high time of 500 + angle*2000/180 ticks.
//   Output channel (out_valid_o / out_stall_i) returns pin levels, running
//   mask and whether the start hit a valid pin, one result per item.
//   Config channel (cfg_valid_i / cfg_ready_o) writes frame_us (index 0) or
//   stop_after_ms (index 1); write it only while the block is idle.
// Timing:
//   One item per cycle sustained while the output does not stall; each
//   result is registered in the result register or skid entry. All channel
//   counters and stop compares update in parallel, which sets that rate.
// Reset: all channels stopped and low, no valid result, registers at defaults.
// Stall: a result register plus one skid entry hold results; input stall
//   rises only once the skid entry is occupied.
// ----------------------------------------------------------------------------
module multi_channel_servo_pulse_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [mcspg_pkg::PinW-1:0]          pin_i,
  input  logic signed [mcspg_pkg::AngleW-1:0] angle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mcspg_pkg::MaskWidth-1:0]     pin_levels_o,
  output logic [mcspg_pkg::MaskWidth-1:0]     running_mask_o,
  output logic                                start_accepted_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mcspg_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [mcspg_pkg::CfgDataW-1:0]      cfg_data_i
);
  import mcspg_pkg::*;

  typedef struct packed {
    logic [MaskWidth-1:0] levels;
    logic [MaskWidth-1:0] running;
    logic                 accepted;
  } result_t;

  logic [FrameW-1:0] frame_q;
  logic [StopW-1:0]  stop_q;

  logic [NumChannels-1:0] running_q, running_d;
  logic [NumChannels-1:0] level_q, level_d;
  logic [HighW-1:0]       high_q [NumChannels];
  logic [HighW-1:0]       high_d [NumChannels];
  logic [FrameW-1:0]      phase_q [NumChannels];
  logic [FrameW-1:0]      phase_d [NumChannels];
  logic [MsW-1:0]         start_ms_q [NumChannels];
  logic [MsW-1:0]         start_ms_d [NumChannels];
  logic [MsW-1:0]         ms_q, ms_d;
  logic [PrescW-1:0]      presc_q, presc_d;

  logic                   in_accept, is_start, is_tick;
  logic [NumChannels-1:0] hit;
  logic [NumChannels-1:0] hold_ch;
  logic [HighW-1:0]       ht_new;
  result_t                res_d, out_q, skid_q;
  logic                   out_valid_q, skid_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign is_start    = in_accept && (command_i == CMD_START);
  assign is_tick     = in_accept && (command_i == CMD_TICK);
  assign ht_new      = high_time(angle_i);

  // first table match wins; channels past the table never start
  always_comb begin
    logic found;
    found = 1'b0;
    for (int i = 0; i < NumChannels; i++) begin
      hit[i]     = 1'b0;
      hold_ch[i] = 1'b0;
      if (i < TableLen) begin
        hold_ch[i] = (PinTable[i] == HoldPin);
        if (!found && PinTable[i] == pin_i) begin
          hit[i] = 1'b1;
          found  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [FrameW-1:0] ph;
    logic              lvl;
    logic [MsW-1:0]    elapsed;
    logic [PrescW-1:0] presc_inc;

    presc_inc = presc_q + 1'b1;
    presc_d   = presc_q;
    ms_d      = ms_q;
    if (is_tick) begin
      if (presc_inc >= UsPerMs) begin
        presc_d = '0;
        ms_d    = ms_q + 1'b1;
      end else begin
        presc_d = presc_inc;
      end
    end

    running_d = running_q;
    level_d   = level_q;
    for (int i = 0; i < NumChannels; i++) begin
      high_d[i]     = high_q[i];
      phase_d[i]    = phase_q[i];
      start_ms_d[i] = start_ms_q[i];
      ph            = phase_q[i] + 1'b1;
      if (ph >= frame_q) begin
        ph = '0;
      end
      lvl     = (ph < FrameW'(high_q[i]));
      elapsed = ms_d - start_ms_q[i];
      if (is_start && hit[i]) begin
        running_d[i]  = 1'b1;
        high_d[i]     = ht_new;
        phase_d[i]    = '0;
        start_ms_d[i] = ms_q;
        level_d[i]    = 1'b1;
      end else if (is_tick && running_q[i]) begin
        phase_d[i] = ph;
        level_d[i] = lvl;
        // stop only once the pulse in progress has ended
        if (!lvl && elapsed >= MsW'(stop_q)) begin
          running_d[i] = 1'b0;
          level_d[i]   = hold_ch[i];
        end
      end
    end

    res_d.levels   = MaskWidth'(level_d);
    res_d.running  = MaskWidth'(running_d);
    res_d.accepted = is_start && (|hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FrameReset;
      stop_q  <= StopReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_US:      frame_q <= cfg_data_i[FrameW-1:0];
        REG_STOP_AFTER_MS: stop_q  <= cfg_data_i[StopW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      level_q   <= '0;
      ms_q      <= '0;
      presc_q   <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        high_q[i]     <= '0;
        phase_q[i]    <= '0;
        start_ms_q[i] <= '0;
      end
    end else if (in_accept) begin
      running_q <= running_d;
      level_q   <= level_d;
      ms_q      <= ms_d;
      presc_q   <= presc_d;
      for (int i = 0; i < NumChannels; i++) begin
        high_q[i]     <= high_d[i];
        phase_q[i]    <= phase_d[i];
        start_ms_q[i] <= start_ms_d[i];
      end
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (in_accept) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (in_accept) begin
        skid_q <= res_d;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_accept) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pin_levels_o     = out_q.levels;
  assign running_mask_o   = out_q.running;
  assign start_accepted_o = out_q.accepted;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry occupied with empty result register");

  a_presc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    presc_q < UsPerMs)
    else $error("microsecond prescaler out of range");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_start && (|hit) && !(out_valid_q && out_stall_i) && !skid_valid_q)
      |=> (out_valid_o && start_accepted_o))
    else $error("accepted start not reported");

  for (genvar g = 0; g < NumChannels; g++) begin : g_chk
    a_level_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
      running_q[g] |-> (level_q[g] == (phase_q[g] < FrameW'(high_q[g]))))
      else $error("running channel level disagrees with its phase");
  end
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the nine-channel servo pulse generator
// Drives ticks and channel starts with bursty input and a random output
// stall pattern. Each result is checked against an in-bench prediction of
// every channel's phase, level, run timer and auto stop, across several
// frame and stop settings.
// ----------------------------------------------------------------------------
module testbench;
  import mcspg_pkg::*;

  localparam int IdleLimit = 2000;

  typedef struct packed {
    logic [MaskWidth-1:0] levels;
    logic [MaskWidth-1:0] running;
    logic                 accepted;
  } servo_out_t;

  class servo_scoreboard;
    logic [FrameW-1:0] frame_us;
    logic [StopW-1:0]  stop_ms;
    logic              ch_running [NumChannels];
    logic [HighW-1:0]  ch_high    [NumChannels];
    logic [FrameW-1:0] ch_phase   [NumChannels];
    logic [MsW-1:0]    ch_start_ms[NumChannels];
    logic              ch_level   [NumChannels];
    logic [MsW-1:0]    ms_count;
    logic [PrescW-1:0] us_count;
    servo_out_t        pending[$];
    int                mismatches;
    int                ticks;
    int                starts_ok;
    int                starts_rejected;
    int                auto_stops;
    int                held_stops;

    function new();
      frame_us = FrameReset;
      stop_ms  = StopReset;
      ms_count = '0;
      us_count = '0;
      for (int i = 0; i < NumChannels; i++) begin
        ch_running[i]  = 1'b0;
        ch_high[i]     = '0;
        ch_phase[i]    = '0;
        ch_start_ms[i] = '0;
        ch_level[i]    = 1'b0;
      end
      mismatches = 0;
      ticks = 0;
      starts_ok = 0;
      starts_rejected = 0;
      auto_stops = 0;
      held_stops = 0;
    endfunction

    function void set_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
      case (idx)
        REG_FRAME_US: begin
          frame_us = data[FrameW-1:0];
        end
        REG_STOP_AFTER_MS: begin
          stop_ms = data[StopW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    // one microsecond: prescaler, then every running channel in parallel
    function void advance_us();
      us_count++;
      if (us_count >= UsPerMs) begin
        us_count = '0;
        ms_count++;
      end
      for (int i = 0; i < NumChannels; i++) begin
        if (ch_running[i]) begin
          ch_phase[i] = ch_phase[i] + 1'b1;
          if (ch_phase[i] >= frame_us) ch_phase[i] = '0;
          ch_level[i] = (ch_phase[i] < ch_high[i]);
          // stop only once the pulse is over
          if (!ch_level[i] && (ms_count - ch_start_ms[i]) >= MsW'(stop_ms)) begin
            ch_running[i] = 1'b0;
            ch_level[i]   = (i < TableLen) && (PinTable[i] == HoldPin);
            auto_stops++;
            if (ch_level[i]) held_stops++;
          end
        end
      end
    endfunction

    function void note_item(input cmd_e cmd, input logic [PinW-1:0] pin,
                            input logic signed [AngleW-1:0] angle);
      servo_out_t exp_out;
      int         ch;
      int         deg;
      exp_out = '0;
      if (cmd == CMD_START) begin
        ch = -1;
        // scan downward so the first table match is the one kept
        for (int i = TableLen - 1; i >= 0; i--) begin
          if (i < NumChannels && PinTable[i] == pin) ch = i;
        end
        deg = int'(angle);
        if (deg < 0) deg = 0;
        else if (deg > 180) deg = 180;
        if (ch >= 0) begin
          ch_running[ch]  = 1'b1;
          ch_high[ch]     = HighW'(500 + deg * 2000 / 180);
          ch_phase[ch]    = '0;
          ch_start_ms[ch] = ms_count;
          ch_level[ch]    = 1'b1;
          exp_out.accepted = 1'b1;
          starts_ok++;
        end else begin
          starts_rejected++;
        end
      end else begin
        ticks++;
        advance_us();
      end
      for (int i = 0; i < NumChannels && i < MaskWidth; i++) begin
        exp_out.levels[i]  = ch_level[i];
        exp_out.running[i] = ch_running[i];
      end
      pending.push_back(exp_out);
    endfunction

    function void check_output(input logic [MaskWidth-1:0] levels,
                               input logic [MaskWidth-1:0] running, input logic accepted);
      servo_out_t exp_out;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: levels %h running %h accepted %b",
                 $time, levels, running, accepted);
        mismatches++;
        return;
      end
      exp_out = pending.pop_front();
      if (levels !== exp_out.levels) begin
        $display("%0t: pin_levels expected %h actual %h", $time, exp_out.levels, levels);
        mismatches++;
      end
      if (running !== exp_out.running) begin
        $display("%0t: running_mask expected %h actual %h", $time, exp_out.running, running);
        mismatches++;
      end
      if (accepted !== exp_out.accepted) begin
        $display("%0t: start_accepted expected %b actual %b", $time, exp_out.accepted,
                 accepted);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       command_i;
  logic [PinW-1:0]            pin_i;
  logic signed [AngleW-1:0]   angle_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [MaskWidth-1:0]       pin_levels_o;
  logic [MaskWidth-1:0]       running_mask_o;
  logic                       start_accepted_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i;
  logic [CfgDataW-1:0]        cfg_data_i;

  servo_scoreboard scoreboard = new();
  int              burst_left = 8;
  int              idle_cycles = 0;
  logic [15:0]     stall_word = '0;
  logic [3:0]      stall_bit = '0;

  multi_channel_servo_pulse_generator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .pin_i            (pin_i),
    .angle_i          (angle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pin_levels_o     (pin_levels_o),
    .running_mask_o   (running_mask_o),
    .start_accepted_o (start_accepted_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: check each transfer, then stall by the bits of a random 16-bit word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      scoreboard.check_output(pin_levels_o, running_mask_o, start_accepted_o);
    end
    if (stall_bit == 4'd0) begin
      case ($urandom_range(0, 3))
        0: stall_word = '0;
        1: stall_word = 16'($urandom() & $urandom());
        2: stall_word = 16'($urandom());
        default: stall_word = 16'($urandom() | $urandom());
      endcase
    end
    out_stall_i <= stall_word[stall_bit];
    stall_bit = stall_bit + 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // returns right after the transfer edge unless a gap follows the burst
  task automatic send_item(input cmd_e cmd, input logic [PinW-1:0] pin,
                           input logic signed [AngleW-1:0] angle);
    int gap;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    pin_i      <= pin;
    angle_i    <= angle;
    do @(posedge clk_i); while (in_stall_o);
    scoreboard.note_item(cmd, pin, angle);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_random(input int start_pct);
    cmd_e                     cmd;
    logic [PinW-1:0]          pin;
    logic signed [AngleW-1:0] angle;
    cmd = ($urandom_range(0, 99) < start_pct) ? CMD_START : CMD_TICK;
    if (cmd == CMD_START && $urandom_range(0, 4) != 0) begin
      pin = PinTable[$urandom_range(0, TableLen - 1)];
    end else begin
      pin = PinW'($urandom_range(0, 31));
    end
    case ($urandom_range(0, 3))
      0: angle = AngleW'($urandom_range(0, 10));
      1, 2: angle = AngleW'($urandom_range(0, 180));
      default: angle = AngleW'($urandom());
    endcase
    send_item(cmd, pin, angle);
  endtask

  // let every pending result drain so the block is idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (scoreboard.pending_count() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    scoreboard.set_reg(idx, data);
  endtask

  task automatic configure(input logic [CfgDataW-1:0] frame, input logic [CfgDataW-1:0] stop);
    write_reg(REG_FRAME_US, frame);
    write_reg(REG_STOP_AFTER_MS, stop);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] frame, input logic [CfgDataW-1:0] stop,
                           input int count, input int start_pct);
    settle();
    configure(frame, stop);
    repeat (count) send_random(start_pct);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    command_i   <= CMD_TICK;
    pin_i       <= '0;
    angle_i     <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_FRAME_US;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every table pin at least once, angle clamps and truncation, unknown pins
    send_item(CMD_TICK,  5'd0,  10'sd0);
    send_item(CMD_START, 5'd0,  10'sd0);
    send_item(CMD_START, 5'd13, 10'sd180);
    send_item(CMD_START, 5'd10, -10'sd512);
    send_item(CMD_START, 5'd16, 10'sd511);
    send_item(CMD_START, 5'd2,  10'sd90);
    send_item(CMD_START, 5'd4,  10'sd1);
    send_item(CMD_START, 5'd5,  10'sd179);
    send_item(CMD_START, 5'd14, -10'sd1);
    send_item(CMD_START, 5'd12, 10'sd181);
    send_item(CMD_START, 5'd1,  10'sd45);
    send_item(CMD_START, 5'd31, -10'sd200);
    send_item(CMD_START, 5'd3,  10'sd60);
    send_item(CMD_TICK,  5'd31, -10'sd1);
    send_item(CMD_TICK,  5'd0,  10'sd0);
    send_item(CMD_START, 5'd0,  10'sd100);
    send_item(CMD_TICK,  5'd0,  10'sd0);

    // zero frame: every running output stays high and nothing stops
    settle();
    configure(16'd0, 16'd0);
    send_item(CMD_TICK,  5'd0,  10'sd0);
    send_item(CMD_TICK,  5'd0,  10'sd0);
    send_item(CMD_START, 5'd10, 10'sd30);
    send_item(CMD_TICK,  5'd0,  10'sd0);

    run_phase(16'd3000,  16'd0,     210, 5);
    // short frame: small angles wrap, larger ones never fall
    run_phase(16'd520,   16'd0,     210, 5);
    run_phase(16'd16383, 16'd65535, 150, 5);
    // one ms limit: channels keep running inside the first millisecond
    run_phase(16'd12000, 16'd1,     260, 3);

    settle();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d ticks and %0d starts, %0d of them on unknown pins",
             scoreboard.ticks, scoreboard.starts_ok + scoreboard.starts_rejected,
             scoreboard.starts_rejected);
    $display("%0d channels stopped on their own, %0d held high on the hold pin",
             scoreboard.auto_stops, scoreboard.held_stops);
    if (scoreboard.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mcspg_pkg.sv
design/multi_channel_servo_pulse_generator.sv
tb/sv/testbench.sv
